[rtl/ryc_pkg.sv]
package ryc_pkg;

  // fixed point fraction bits of the encode coefficients
  localparam int unsigned COEF_FRACTION_BITS = 16;

  // field widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned WORD_W = 16;

  // decode coefficients, exact in five fraction bits
  localparam int unsigned DEC_FRAC_BITS = 5;
  localparam int unsigned DEC_COEF_R_V  = 44;
  localparam int unsigned DEC_COEF_G_U  = 11;
  localparam int unsigned DEC_COEF_G_V  = 22;
  localparam int unsigned DEC_COEF_B_U  = 55;

  // direction register codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // request payload: one pixel pair or one word pair
  typedef struct packed {
    logic [PIX_W-1:0]  red_first;
    logic [PIX_W-1:0]  green_first;
    logic [PIX_W-1:0]  blue_first;
    logic [PIX_W-1:0]  red_second;
    logic [PIX_W-1:0]  green_second;
    logic [PIX_W-1:0]  blue_second;
    logic [WORD_W-1:0] word_first;
    logic [WORD_W-1:0] word_second;
  } in_req_t;

  // result payload
  typedef struct packed {
    logic [WORD_W-1:0] packed_first;
    logic [WORD_W-1:0] packed_second;
    logic [PIX_W-1:0]  out_red_first;
    logic [PIX_W-1:0]  out_green_first;
    logic [PIX_W-1:0]  out_blue_first;
    logic [PIX_W-1:0]  out_red_second;
    logic [PIX_W-1:0]  out_green_second;
    logic [PIX_W-1:0]  out_blue_second;
  } out_rsp_t;

endpackage

[rtl/ryc_in_if.sv]
interface ryc_in_if import ryc_pkg::*;;

  logic    valid;
  logic    ready;
  in_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

[rtl/ryc_out_if.sv]
interface ryc_out_if import ryc_pkg::*;;

  logic     valid;
  logic     ready;
  out_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

[rtl/ryc_enc_lane.sv]
module ryc_enc_lane #(
  parameter int unsigned               CoefFracBits = 16,
  parameter logic [CoefFracBits-1:0]   CoefA        = '0,
  parameter logic [CoefFracBits-1:0]   CoefB        = '0,
  parameter logic [CoefFracBits-1:0]   CoefC        = '0,
  parameter bit                        NegA         = 1'b0,
  parameter bit                        NegB         = 1'b0,
  parameter bit                        NegC         = 1'b0,
  parameter bit                        BiasEn       = 1'b0
) (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [7:0] a_i,
  input  logic [7:0] b_i,
  input  logic [7:0] c_i,
  output logic [7:0] res_o
);

  localparam int unsigned ProdW = CoefFracBits + 8;
  localparam int unsigned SumW  = CoefFracBits + 11;
  localparam int unsigned HiW   = SumW - 1 - CoefFracBits;
  localparam logic [SumW-1:0] BiasVal =
    BiasEn ? (SumW'(128) << CoefFracBits) : '0;

  logic [ProdW-1:0] pa_q, pb_q, pc_q;
  logic [SumW-1:0]  ea, eb, ec;
  logic [SumW-1:0]  sum;
  logic [HiW-1:0]   hi;

  // product register, one multiplier per term
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q <= ProdW'(a_i) * ProdW'(CoefA);
      pb_q <= ProdW'(b_i) * ProdW'(CoefB);
      pc_q <= ProdW'(c_i) * ProdW'(CoefC);
    end
  end

  // signed sum with bias, then truncate and clamp to 0..255
  always_comb begin
    ea  = NegA ? -SumW'(pa_q) : SumW'(pa_q);
    eb  = NegB ? -SumW'(pb_q) : SumW'(pb_q);
    ec  = NegC ? -SumW'(pc_q) : SumW'(pc_q);
    sum = BiasVal + ea + eb + ec;
    hi  = sum[SumW-2:CoefFracBits];
    if (sum[SumW-1]) begin
      res_o = 8'd0;
    end else if (|hi[HiW-1:8]) begin
      res_o = 8'd255;
    end else begin
      res_o = hi[7:0];
    end
  end

endmodule

[rtl/ryc_dec_lane.sv]
module ryc_dec_lane import ryc_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [PIX_W-1:0] y_i,
  input  logic [PIX_W-1:0] u_i,
  input  logic [PIX_W-1:0] v_i,
  output logic [PIX_W-1:0] red_o,
  output logic [PIX_W-1:0] green_o,
  output logic [PIX_W-1:0] blue_o
);

  localparam int unsigned DW  = 16;
  localparam int unsigned HiW = DW - 1 - DEC_FRAC_BITS;
  localparam logic signed [DW-1:0] KRv = DW'(DEC_COEF_R_V);
  localparam logic signed [DW-1:0] KGu = DW'(DEC_COEF_G_U);
  localparam logic signed [DW-1:0] KGv = DW'(DEC_COEF_G_V);
  localparam logic signed [DW-1:0] KBu = DW'(DEC_COEF_B_U);

  function automatic logic [PIX_W-1:0] clamp_px(logic signed [DW-1:0] s);
    logic [HiW-1:0] hi;
    hi = s[DW-2:DEC_FRAC_BITS];
    if (s[DW-1]) begin
      return '0;
    end else if (|hi[HiW-1:PIX_W]) begin
      return '1;
    end else begin
      return hi[PIX_W-1:0];
    end
  endfunction

  logic signed [8:0]    u_s, v_s;
  logic signed [DW-1:0] u_e, v_e;
  logic signed [DW-1:0] ys_q, rv_q, gu_q, gv_q, bu_q;
  logic signed [DW-1:0] r_sum, g_sum, b_sum;

  // remove chroma bias
  assign u_s = $signed({1'b0, u_i}) - 9'sd128;
  assign v_s = $signed({1'b0, v_i}) - 9'sd128;
  assign u_e = DW'(u_s);
  assign v_e = DW'(v_s);

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ys_q <= $signed(DW'(y_i) << DEC_FRAC_BITS);
      rv_q <= KRv * v_e;
      gu_q <= KGu * u_e;
      gv_q <= KGv * v_e;
      bu_q <= KBu * u_e;
    end
  end

  // sums, truncate and clamp
  always_comb begin
    r_sum   = ys_q + rv_q;
    g_sum   = ys_q - gu_q - gv_q;
    b_sum   = ys_q + bu_q;
    red_o   = clamp_px(r_sum);
    green_o = clamp_px(g_sum);
    blue_o  = clamp_px(b_sum);
  end

endmodule

[rtl/rgb_yuv422_converter_top.sv]
// Converts one pixel pair per clock between RGB and packed YUV 4:2:2. With
// direction 0 the two RGB pixels become two words, luma0:U and luma1:V, where
// U and V come from the floored average of the pair; with direction 1 the two
// words are decoded back to two RGB pixels. Each request passes through the
// lane product registers and then the output register. A new request is
// taken every cycle as long as the output register is empty or being
// drained; ready is high exactly then. Write direction only while no
// request is in flight.
module rgb_yuv422_converter_top import ryc_pkg::*; #(
  parameter int unsigned CoefFracBits = COEF_FRACTION_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ryc_in_if.sink    req_i,
  ryc_out_if.source rsp_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  // encode coefficients, rounded to nearest
  localparam logic [CoefFracBits-1:0] CoefYr =
    CoefFracBits'(((64'd299 << CoefFracBits) + 64'd500) / 64'd1000);
  localparam logic [CoefFracBits-1:0] CoefYg =
    CoefFracBits'(((64'd587 << CoefFracBits) + 64'd500) / 64'd1000);
  localparam logic [CoefFracBits-1:0] CoefYb =
    CoefFracBits'(((64'd114 << CoefFracBits) + 64'd500) / 64'd1000);
  localparam logic [CoefFracBits-1:0] CoefUr =
    CoefFracBits'(((64'd169 << CoefFracBits) + 64'd500) / 64'd1000);
  localparam logic [CoefFracBits-1:0] CoefUg =
    CoefFracBits'(((64'd331 << CoefFracBits) + 64'd500) / 64'd1000);
  localparam logic [CoefFracBits-1:0] CoefUb =
    CoefFracBits'(((64'd499 << CoefFracBits) + 64'd500) / 64'd1000);
  localparam logic [CoefFracBits-1:0] CoefVr = CoefUb;
  localparam logic [CoefFracBits-1:0] CoefVg =
    CoefFracBits'(((64'd418 << CoefFracBits) + 64'd500) / 64'd1000);
  localparam logic [CoefFracBits-1:0] CoefVb =
    CoefFracBits'(((64'd813 << CoefFracBits) + 64'd5000) / 64'd10000);

  logic     direction_q;
  logic     s1_valid_q, s1_dir_q;
  logic     out_valid_q;
  out_rsp_t out_q, out_d;
  logic     en;

  logic [PIX_W:0]   sum_r, sum_g, sum_b;
  logic [PIX_W-1:0] avg_r, avg_g, avg_b;
  logic [PIX_W-1:0] y0, y1, u_enc, v_enc;
  logic [PIX_W-1:0] r0, g0, b0, r1, g1, b1;

  // direction register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= DIR_ENCODE;
    end else if (cfg_we_i) begin
      direction_q <= cfg_wdata_i;
    end
  end

  // pipeline advances whenever the output register can take a result
  assign en          = !out_valid_q || rsp_o.ready;
  assign req_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= req_i.valid;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dir_q <= direction_q;
      out_q    <= out_d;
    end
  end

  // floored channel averages for chroma
  always_comb begin
    sum_r = {1'b0, req_i.payload.red_first} + {1'b0, req_i.payload.red_second};
    sum_g = {1'b0, req_i.payload.green_first} + {1'b0, req_i.payload.green_second};
    sum_b = {1'b0, req_i.payload.blue_first} + {1'b0, req_i.payload.blue_second};
    avg_r = sum_r[PIX_W:1];
    avg_g = sum_g[PIX_W:1];
    avg_b = sum_b[PIX_W:1];
  end

  // encode lanes: two luma, one per chroma
  ryc_enc_lane #(
    .CoefFracBits(CoefFracBits), .CoefA(CoefYr), .CoefB(CoefYg), .CoefC(CoefYb)
  ) u_y0_lane (
    .clk_i, .en_i(en), .a_i(req_i.payload.red_first), .b_i(req_i.payload.green_first),
    .c_i(req_i.payload.blue_first), .res_o(y0)
  );

  ryc_enc_lane #(
    .CoefFracBits(CoefFracBits), .CoefA(CoefYr), .CoefB(CoefYg), .CoefC(CoefYb)
  ) u_y1_lane (
    .clk_i, .en_i(en), .a_i(req_i.payload.red_second), .b_i(req_i.payload.green_second),
    .c_i(req_i.payload.blue_second), .res_o(y1)
  );

  ryc_enc_lane #(
    .CoefFracBits(CoefFracBits), .CoefA(CoefUr), .CoefB(CoefUg), .CoefC(CoefUb),
    .NegA(1'b1), .NegB(1'b1), .NegC(1'b0), .BiasEn(1'b1)
  ) u_u_lane (
    .clk_i, .en_i(en), .a_i(avg_r), .b_i(avg_g), .c_i(avg_b), .res_o(u_enc)
  );

  ryc_enc_lane #(
    .CoefFracBits(CoefFracBits), .CoefA(CoefVr), .CoefB(CoefVg), .CoefC(CoefVb),
    .NegA(1'b0), .NegB(1'b1), .NegC(1'b1), .BiasEn(1'b1)
  ) u_v_lane (
    .clk_i, .en_i(en), .a_i(avg_r), .b_i(avg_g), .c_i(avg_b), .res_o(v_enc)
  );

  // decode lanes, one per pixel, sharing the chroma bytes
  ryc_dec_lane u_dec0_lane (
    .clk_i, .en_i(en),
    .y_i(req_i.payload.word_first[WORD_W-1:PIX_W]),
    .u_i(req_i.payload.word_first[PIX_W-1:0]),
    .v_i(req_i.payload.word_second[PIX_W-1:0]),
    .red_o(r0), .green_o(g0), .blue_o(b0)
  );

  ryc_dec_lane u_dec1_lane (
    .clk_i, .en_i(en),
    .y_i(req_i.payload.word_second[WORD_W-1:PIX_W]),
    .u_i(req_i.payload.word_first[PIX_W-1:0]),
    .v_i(req_i.payload.word_second[PIX_W-1:0]),
    .red_o(r1), .green_o(g1), .blue_o(b1)
  );

  // merge lane results by direction, unused fields are zero
  always_comb begin
    out_d = '0;
    if (s1_dir_q == DIR_DECODE) begin
      out_d.out_red_first    = r0;
      out_d.out_green_first  = g0;
      out_d.out_blue_first   = b0;
      out_d.out_red_second   = r1;
      out_d.out_green_second = g1;
      out_d.out_blue_second  = b1;
    end else begin
      out_d.packed_first  = {y0, u_enc};
      out_d.packed_second = {y1, v_enc};
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // a stalled result blocks new requests
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |-> !req_i.ready)
    else $error("request accepted while result stalled");

  // an accepted request reaches the lane registers
  a_accept_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> s1_valid_q)
    else $error("accepted request lost before lane stage");

  // a lane result moves into the output register when the pipe advances
  a_s1_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && en |=> rsp_o.valid)
    else $error("lane result lost before output register");

  // an encoded result carries no decoded colors
  a_modes_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.payload.packed_first != '0 || rsp_o.payload.packed_second != '0)
    |-> rsp_o.payload.out_red_first == '0 && rsp_o.payload.out_green_first == '0 &&
        rsp_o.payload.out_blue_first == '0 && rsp_o.payload.out_red_second == '0 &&
        rsp_o.payload.out_green_second == '0 && rsp_o.payload.out_blue_second == '0)
    else $error("encode and decode fields both set");

endmodule

[verif/ryc_conversion_checker.sv]
`timescale 1ns / 1ps

module ryc_conversion_checker import ryc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  ryc_in_if    req_mon_i,
  ryc_out_if   rsp_mon_i,
  output int   error_count_o,
  output int   pending_count_o
);

  // encode coefficients, magnitudes rounded to nearest in the fixed point scale
  localparam longint Unit     = longint'(1) << COEF_FRACTION_BITS;
  localparam longint LumaR    = (299 * Unit + 500) / 1000;
  localparam longint LumaG    = (587 * Unit + 500) / 1000;
  localparam longint LumaB    = (114 * Unit + 500) / 1000;
  localparam longint CbR      = (169 * Unit + 500) / 1000;
  localparam longint CbG      = (331 * Unit + 500) / 1000;
  localparam longint CbB      = (499 * Unit + 500) / 1000;
  localparam longint CrR      = (499 * Unit + 500) / 1000;
  localparam longint CrG      = (418 * Unit + 500) / 1000;
  localparam longint CrB      = (813 * Unit + 5000) / 10000;
  localparam longint ChromaOfs = 128 * Unit;

  // decode coefficients as signed values
  localparam longint DecRV = longint'(DEC_COEF_R_V);
  localparam longint DecGU = longint'(DEC_COEF_G_U);
  localparam longint DecGV = longint'(DEC_COEF_G_V);
  localparam longint DecBU = longint'(DEC_COEF_B_U);

  localparam int MaxReports = 10;

  out_rsp_t pending_pairs [$];
  out_rsp_t oldest_pair;
  logic     direction_q;
  int       failures;
  int       reports;
  string    field_names [8] = '{"packed_first", "packed_second", "out_red_first",
                                "out_green_first", "out_blue_first", "out_red_second",
                                "out_green_second", "out_blue_second"};

  // negative sums floor at zero, otherwise truncate and saturate
  function automatic logic [7:0] clamp_shift(input longint sum, input int unsigned sh);
    longint q;
    if (sum < 0) return 8'd0;
    q = sum >>> sh;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic void rebuild_pixel(input longint y, input longint u, input longint v,
                                        output logic [7:0] r, output logic [7:0] g,
                                        output logic [7:0] b);
    longint ys;
    ys = y <<< DEC_FRAC_BITS;
    r  = clamp_shift(ys + DecRV * v, DEC_FRAC_BITS);
    g  = clamp_shift(ys - DecGU * u - DecGV * v, DEC_FRAC_BITS);
    b  = clamp_shift(ys + DecBU * u, DEC_FRAC_BITS);
  endfunction

  function automatic out_rsp_t convert_pair(input in_req_t item, input logic dir);
    out_rsp_t res;
    longint   r0, g0, b0, r1, g1, b1, ar, ag, ab, y0w, y1w, uw, vw;
    logic [7:0] y0, y1, cb, cr;
    res = '0;
    if (dir == DIR_ENCODE) begin
      r0 = item.red_first;
      g0 = item.green_first;
      b0 = item.blue_first;
      r1 = item.red_second;
      g1 = item.green_second;
      b1 = item.blue_second;
      // chroma uses the floored pair average
      ar = (r0 + r1) / 2;
      ag = (g0 + g1) / 2;
      ab = (b0 + b1) / 2;
      y0 = clamp_shift(LumaR * r0 + LumaG * g0 + LumaB * b0, COEF_FRACTION_BITS);
      y1 = clamp_shift(LumaR * r1 + LumaG * g1 + LumaB * b1, COEF_FRACTION_BITS);
      cb = clamp_shift(ChromaOfs - CbR * ar - CbG * ag + CbB * ab, COEF_FRACTION_BITS);
      cr = clamp_shift(ChromaOfs + CrR * ar - CrG * ag - CrB * ab, COEF_FRACTION_BITS);
      res.packed_first  = {y0, cb};
      res.packed_second = {y1, cr};
    end else begin
      y0w = item.word_first[15:8];
      y1w = item.word_second[15:8];
      uw  = longint'(item.word_first[7:0]) - 128;
      vw  = longint'(item.word_second[7:0]) - 128;
      rebuild_pixel(y0w, uw, vw, res.out_red_first, res.out_green_first, res.out_blue_first);
      rebuild_pixel(y1w, uw, vw, res.out_red_second, res.out_green_second,
                    res.out_blue_second);
    end
    return res;
  endfunction

  task automatic compare_pair(input out_rsp_t got, input out_rsp_t want);
    logic [15:0] got_f  [8];
    logic [15:0] want_f [8];
    bit          bad;
    got_f  = '{got.packed_first, got.packed_second, 16'(got.out_red_first),
               16'(got.out_green_first), 16'(got.out_blue_first), 16'(got.out_red_second),
               16'(got.out_green_second), 16'(got.out_blue_second)};
    want_f = '{want.packed_first, want.packed_second, 16'(want.out_red_first),
               16'(want.out_green_first), 16'(want.out_blue_first), 16'(want.out_red_second),
               16'(want.out_green_second), 16'(want.out_blue_second)};
    bad = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (got_f[i] !== want_f[i]) begin
        if (reports < MaxReports)
          $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field_names[i],
                   want_f[i], got_f[i]);
        bad = 1'b1;
      end
    end
    if (bad) begin
      failures++;
      reports++;
    end
  endtask

  // track results against the oldest prediction, then log new requests
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      direction_q = DIR_ENCODE;
    end else begin
      if (rsp_mon_i.valid && rsp_mon_i.ready) begin
        if (pending_pairs.size() == 0) begin
          if (reports < MaxReports)
            $display("%0t: result %h with no request outstanding", $realtime,
                     rsp_mon_i.payload);
          failures++;
          reports++;
        end else begin
          oldest_pair = pending_pairs.pop_front();
          compare_pair(rsp_mon_i.payload, oldest_pair);
        end
      end
      if (req_mon_i.valid && req_mon_i.ready)
        pending_pairs.push_back(convert_pair(req_mon_i.payload, direction_q));
      if (cfg_we_i)
        direction_q = cfg_wdata_i;
    end
    pending_count_o <= pending_pairs.size();
    error_count_o   <= failures;
  end

  initial begin
    direction_q     = DIR_ENCODE;
    failures        = 0;
    reports         = 0;
    pending_count_o = 0;
    error_count_o   = 0;
  end

endmodule

[verif/rgb_yuv422_converter_top_tb.sv]
`timescale 1ns / 1ps

module rgb_yuv422_converter_top_tb;
  import ryc_pkg::*;

  localparam int LongHold = 300;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;
  int   error_count;
  int   pending_count;
  int   sender_idle_pct   = 0;
  int   receiver_idle_pct = 0;
  int   hold_left         = 0;
  bit   stall_toggle      = 1'b0;
  bit   stall_seen        = 1'b0;

  ryc_in_if  req_ch ();
  ryc_out_if rsp_ch ();

  rgb_yuv422_converter_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  ryc_conversion_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_mon_i       (req_ch),
    .rsp_mon_i       (rsp_ch),
    .error_count_o   (error_count),
    .pending_count_o (pending_count)
  );

  always #10 clk_i = ~clk_i;

  // result side: random back-pressure, plus a long hold-off on demand
  always @(posedge clk_i) begin
    if (stall_toggle != stall_seen) begin
      stall_seen    <= stall_toggle;
      hold_left     <= LongHold;
      rsp_ch.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      rsp_ch.ready  <= 1'b0;
    end else begin
      rsp_ch.ready  <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // offer one request, leaving valid high at the accepting edge
  task automatic send_pair(input in_req_t item);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= item;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // drop valid and wait until every result has come back
  task automatic drain_requests();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending_count == 0);
  endtask

  task automatic set_direction(input logic dir);
    drain_requests();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= dir;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // bytes lean toward the extremes now and then
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random(input int count);
    in_req_t item;
    repeat (count) begin
      item = '{rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(),
               {rand_byte(), rand_byte()}, {rand_byte(), rand_byte()}};
      send_pair(item);
    end
  endtask

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = DIR_ENCODE;
    rst_ni         = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender sparse, receiver busy
    sender_idle_pct   = 35;
    receiver_idle_pct = 71;
    set_direction(DIR_ENCODE);
    // encode corners: black, white, primaries, floored averages, ignored words
    send_pair('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000});
    send_pair('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff});
    send_pair('{8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 16'h0000, 16'h0000});
    send_pair('{8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 16'h0000, 16'h0000});
    send_pair('{8'h00, 8'h00, 8'hff, 8'h00, 8'h00, 8'hff, 16'h0000, 16'h0000});
    send_pair('{8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000});
    send_pair('{8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000});
    send_pair('{8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff, 16'h1234, 16'habcd});
    send_pair('{8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 16'h5555, 16'haaaa});
    send_random(180);

    set_direction(DIR_DECODE);
    // decode corners: negative clamp, saturation, neutral chroma, ignored pixels
    send_pair('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 16'h0000, 16'h0000});
    send_pair('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'hffff, 16'hffff});
    send_pair('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0080, 16'h0080});
    send_pair('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'hff80, 16'h0080});
    send_pair('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h00ff, 16'h8000});
    send_pair('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'h8000, 16'h80ff});
    send_pair('{8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc, 16'h80ff, 16'h80ff});
    send_pair('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'haa55, 16'h55aa});
    send_random(180);

    // sender busy, receiver sparse
    sender_idle_pct   = 71;
    receiver_idle_pct = 35;
    set_direction(DIR_ENCODE);
    send_random(190);
    set_direction(DIR_DECODE);
    send_random(190);

    // no idling; long receiver hold-off fills the pipe, then a full pause
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    set_direction(DIR_ENCODE);
    stall_toggle = ~stall_toggle;
    send_random(100);
    drain_requests();
    send_random(100);
    set_direction(DIR_DECODE);
    send_random(200);

    drain_requests();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && pending_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

[rgb_yuv422_converter_top.f]
rtl/ryc_pkg.sv
rtl/ryc_in_if.sv
rtl/ryc_out_if.sv
rtl/ryc_enc_lane.sv
rtl/ryc_dec_lane.sv
rtl/rgb_yuv422_converter_top.sv
verif/ryc_conversion_checker.sv
verif/rgb_yuv422_converter_top_tb.sv
